### rtl/idm_pkg.sv
`default_nettype none
package idm_pkg;

	localparam int PORT_W     = 64;
	localparam int DATA_W_DEF = 64;

	typedef enum logic [1:0] {
		KIND_UQUO = 2'd0,
		KIND_UREM = 2'd1,
		KIND_SQUO = 2'd2,
		KIND_SREM = 2'd3
	} kind_t;

	// side info that travels with each beat down the cell row
	typedef struct packed {
		logic valid;
		logic want_rem;
		logic neg_q;
		logic neg_r;
		logic zero;
	} ctl_t;

endpackage
`default_nettype wire

### rtl/idm_prep.sv
`default_nettype none
module idm_prep #(
	parameter int DATA_WIDTH = idm_pkg::DATA_W_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [1:0]            kind,
	input  wire logic [DATA_WIDTH-1:0] dividend,
	input  wire logic [DATA_WIDTH-1:0] divisor,
	output idm_pkg::ctl_t              ctl_s1,
	output logic [DATA_WIDTH-1:0]      num_s1,
	output logic [DATA_WIDTH-1:0]      dsor_s1
);

	logic          is_signed;
	logic          want_rem;
	logic          sa;
	logic          sb;
	idm_pkg::ctl_t ctl_d;

	always_comb begin
		case (idm_pkg::kind_t'(kind))
			idm_pkg::KIND_UQUO: begin is_signed = 1'b0; want_rem = 1'b0; end
			idm_pkg::KIND_UREM: begin is_signed = 1'b0; want_rem = 1'b1; end
			idm_pkg::KIND_SQUO: begin is_signed = 1'b1; want_rem = 1'b0; end
			idm_pkg::KIND_SREM: begin is_signed = 1'b1; want_rem = 1'b1; end
			default: begin is_signed = 1'b0; want_rem = 1'b0; end
		endcase
		sa = is_signed & dividend[DATA_WIDTH-1];
		sb = is_signed & divisor[DATA_WIDTH-1];
		ctl_d.valid    = start;
		ctl_d.want_rem = want_rem;
		ctl_d.neg_q    = sa ^ sb;
		ctl_d.neg_r    = sa;
		ctl_d.zero     = (divisor == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		num_s1  <= sa ? (~dividend + 1'b1) : dividend;
		dsor_s1 <= sb ? (~divisor + 1'b1) : divisor;
	end

endmodule
`default_nettype wire

### rtl/idm_cell.sv
`default_nettype none
module idm_cell #(
	parameter int DATA_WIDTH = idm_pkg::DATA_W_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire idm_pkg::ctl_t         ctl_in,
	input  wire logic [DATA_WIDTH-1:0] rem_in,
	input  wire logic [DATA_WIDTH-1:0] num_in,
	input  wire logic [DATA_WIDTH-1:0] quo_in,
	input  wire logic [DATA_WIDTH-1:0] dsor_in,
	output idm_pkg::ctl_t              ctl_q,
	output logic [DATA_WIDTH-1:0]      rem_q,
	output logic [DATA_WIDTH-1:0]      num_q,
	output logic [DATA_WIDTH-1:0]      quo_q,
	output logic [DATA_WIDTH-1:0]      dsor_q
);

	logic [DATA_WIDTH:0] wide;
	logic [DATA_WIDTH:0] diff;
	logic                take;

	// partial remainder keeps its carry-out, so the compare is W+1 bits
	always_comb begin
		wide = {rem_in, num_in[DATA_WIDTH-1]};
		diff = wide - {1'b0, dsor_in};
		take = (wide >= {1'b0, dsor_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= take ? diff[DATA_WIDTH-1:0] : wide[DATA_WIDTH-1:0];
		num_q  <= {num_in[DATA_WIDTH-2:0], 1'b0};
		quo_q  <= {quo_in[DATA_WIDTH-2:0], take};
		dsor_q <= dsor_in;
	end

endmodule
`default_nettype wire

### rtl/idm_fix.sv
`default_nettype none
module idm_fix #(
	parameter int DATA_WIDTH = idm_pkg::DATA_W_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire idm_pkg::ctl_t              ctl,
	input  wire logic [DATA_WIDTH-1:0]      rem,
	input  wire logic [DATA_WIDTH-1:0]      quo,
	output logic                            done_q,
	output logic [idm_pkg::PORT_W-1:0]      result_q,
	output logic                            dbz_q
);

	logic [DATA_WIDTH-1:0] res;

	// zero divisor: the row leaves all ones in quo and the dividend magnitude in rem
	always_comb begin
		if (ctl.want_rem) begin
			res = ctl.neg_r ? (~rem + 1'b1) : rem;
		end else if (ctl.zero) begin
			res = '0;
		end else begin
			res = ctl.neg_q ? (~quo + 1'b1) : quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= idm_pkg::PORT_W'(res);
		dbz_q    <= ctl.zero;
	end

endmodule
`default_nettype wire

### rtl/int64_divide_modulo_top.sv
`default_nettype none
// Pipeline: start runs to done through operand prep, one cell per
// quotient bit and the sign fix-up.
// Throughput: one beat per cycle, set by the row of restoring-step cells;
// busy is always low.
// Reset: arst_n clears the valid bits of every stage; data registers are not reset.
module int64_divide_modulo_top #(
	parameter int DATA_WIDTH = idm_pkg::DATA_W_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   kind,
	input  wire logic [idm_pkg::PORT_W-1:0]   dividend,
	input  wire logic [idm_pkg::PORT_W-1:0]   divisor,
	output logic                              done,
	output logic [idm_pkg::PORT_W-1:0]        result,
	output logic                              divide_by_zero
);

	idm_pkg::ctl_t         ctl_c  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_c  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] num_c  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] quo_c  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] dsor_c [0:DATA_WIDTH];

	assign busy     = 1'b0;
	assign rem_c[0] = '0;
	assign quo_c[0] = '0;

	idm_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.kind     (kind),
		.dividend (dividend[DATA_WIDTH-1:0]),
		.divisor  (divisor[DATA_WIDTH-1:0]),
		.ctl_s1   (ctl_c[0]),
		.num_s1   (num_c[0]),
		.dsor_s1  (dsor_c[0])
	);

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		idm_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_c[i]),
			.rem_in  (rem_c[i]),
			.num_in  (num_c[i]),
			.quo_in  (quo_c[i]),
			.dsor_in (dsor_c[i]),
			.ctl_q   (ctl_c[i+1]),
			.rem_q   (rem_c[i+1]),
			.num_q   (num_c[i+1]),
			.quo_q   (quo_c[i+1]),
			.dsor_q  (dsor_c[i+1])
		);
	end

	idm_fix #(.DATA_WIDTH(DATA_WIDTH)) u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_c[DATA_WIDTH]),
		.rem      (rem_c[DATA_WIDTH]),
		.quo      (quo_c[DATA_WIDTH]),
		.done_q   (done),
		.result_q (result),
		.dbz_q    (divide_by_zero)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(DATA_WIDTH+2) done)
		else $error("beat lost in cell row");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl_c[0].valid && !ctl_c[DATA_WIDTH].valid |=> !done)
		else $error("done without a beat");

	a_zero_quo: assert property (@(posedge clk) disable iff (!arst_n)
		start && (divisor[DATA_WIDTH-1:0] == '0) &&
		(kind == idm_pkg::KIND_UQUO || kind == idm_pkg::KIND_SQUO)
		|-> ##(DATA_WIDTH+2) (done && divide_by_zero && result == '0))
		else $error("zero divisor quotient not forced to zero");

	a_zero_rem: assert property (@(posedge clk) disable iff (!arst_n)
		start && (divisor[DATA_WIDTH-1:0] == '0) && kind == idm_pkg::KIND_UREM
		|-> ##(DATA_WIDTH+2)
		(result[DATA_WIDTH-1:0] == $past(dividend[DATA_WIDTH-1:0], DATA_WIDTH+2)))
		else $error("zero divisor remainder differs from dividend");

	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result >> DATA_WIDTH) == '0))
		else $error("result bits above width not zero");
`endif

endmodule
`default_nettype wire

### tb/sv/idm_div_checker.sv
`default_nettype none
module idm_div_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  kind,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	input  wire logic        done,
	input  wire logic [63:0] result,
	input  wire logic        divide_by_zero,
	output int               mismatches,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] value;
		logic        dz;
	} div_outcome_t;

	div_outcome_t awaited_q[$];

	// Signed kinds work on magnitudes; the quotient sign is the xor of both
	// signs, the remainder follows the dividend. Negation wraps at 64 bits.
	function automatic div_outcome_t predict_divide(idm_pkg::kind_t k, logic [63:0] num,
			logic [63:0] den);
		div_outcome_t outc;
		logic         is_signed;
		logic         want_rem;
		logic         num_neg;
		logic         den_neg;
		logic [63:0]  num_mag;
		logic [63:0]  den_mag;
		logic [63:0]  quo;
		logic [63:0]  rem;
		is_signed = (k == idm_pkg::KIND_SQUO) || (k == idm_pkg::KIND_SREM);
		want_rem  = (k == idm_pkg::KIND_UREM) || (k == idm_pkg::KIND_SREM);
		num_neg   = is_signed & num[63];
		den_neg   = is_signed & den[63];
		num_mag   = num_neg ? 64'(-num) : num;
		den_mag   = den_neg ? 64'(-den) : den;
		if (den_mag == 64'd0) begin
			quo = 64'd0;
			rem = num_mag;
		end else begin
			quo = num_mag / den_mag;
			rem = num_mag % den_mag;
		end
		if (want_rem)
			outc.value = num_neg ? 64'(-rem) : rem;
		else
			outc.value = (num_neg ^ den_neg) ? 64'(-quo) : quo;
		outc.dz = (den == 64'd0);
		return outc;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		div_outcome_t want;
		int           bad;
		if (!arst_n) begin
			awaited_q.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			bad = 0;
			if (done) begin
				if (awaited_q.size() == 0) begin
					$display("%0t unexpected result beat: actual result %h divide_by_zero %b",
						$time, result, divide_by_zero);
					bad++;
				end else begin
					want = awaited_q.pop_front();
					if (result !== want.value) begin
						$display("%0t result mismatch: expected %h actual %h",
							$time, want.value, result);
						bad++;
					end
					if (divide_by_zero !== want.dz) begin
						$display("%0t divide_by_zero mismatch: expected %b actual %b",
							$time, want.dz, divide_by_zero);
						bad++;
					end
				end
			end
			if (start && !busy)
				awaited_q.push_back(predict_divide(idm_pkg::kind_t'(kind), dividend,
					divisor));
			mismatches <= mismatches + bad;
			pending    <= awaited_q.size();
		end
	end

endmodule
`default_nettype wire

### tb/sv/int64_divide_modulo_top_tb.sv
`default_nettype none
module int64_divide_modulo_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1280;
	localparam int CALM_TAIL    = 200;
	localparam int DRAIN_CYCLES = 80;

	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [63:0] corner_vals [6] = '{
		64'd0, 64'd1, ALL_ONES, MOST_NEG, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001
	};

	// directed pairs, each applied under every kind
	localparam logic [63:0] probe_num [6] = '{
		MOST_NEG, ALL_ONES, 64'h1234_5678_9ABC_DEF0,
		64'hFFFF_FFFF_FFFF_FFF9, 64'd7, ALL_ONES
	};
	localparam logic [63:0] probe_den [6] = '{
		ALL_ONES, 64'd1, 64'd0,
		64'd2, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        start    = 1'b0;
	logic [1:0]  kind     = idm_pkg::KIND_UQUO;
	logic [63:0] dividend = 64'd0;
	logic [63:0] divisor  = 64'd0;
	wire logic        busy;
	wire logic        done;
	wire logic [63:0] result;
	wire logic        divide_by_zero;
	int mismatches;
	int pending;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	int64_divide_modulo_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.dividend       (dividend),
		.divisor        (divisor),
		.done           (done),
		.result         (result),
		.divide_by_zero (divide_by_zero)
	);

	idm_div_checker scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.dividend       (dividend),
		.divisor        (divisor),
		.done           (done),
		.result         (result),
		.divide_by_zero (divide_by_zero),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [63:0] random_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = v >> $urandom_range(0, 63);
			1: v = 64'(-(v >> $urandom_range(32, 63)));
			2: v = 64'($urandom_range(0, 20));
			3: v = corner_vals[$urandom_range(0, 5)];
			default: ;
		endcase
		return v;
	endfunction

	// holds start high until the beat is taken
	task automatic push_beat(idm_pkg::kind_t k, logic [63:0] num, logic [63:0] den);
		start    <= 1'b1;
		kind     <= k;
		dividend <= num;
		divisor  <= den;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(int cycles);
		start    <= 1'b0;
		kind     <= 2'($urandom);
		dividend <= {$urandom, $urandom};
		divisor  <= {$urandom, $urandom};
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < 4; k++)
			for (int p = 0; p < 6; p++)
				push_beat(idm_pkg::kind_t'(k), probe_num[p], probe_den[p]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			push_beat(idm_pkg::kind_t'($urandom_range(0, 3)), random_operand(),
				random_operand());
			if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 11));
		end
		start <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
